// ===== rtl/core/sbis_pkg.sv =====
`default_nettype none
package sbis_pkg;

  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_VALUE_BITS  = 32;

  localparam int IDX_BITS   = 4;
  localparam int CFG_BITS   = 5;
  localparam int INTV_BITS  = 5;
  localparam int OUT_BITS   = 8;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QFIRST,
    ST_QSTEP,
    ST_LLO,
    ST_LHI,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    RD_ACCEPT,
    RD_MID,
    RD_NEXT,
    RD_HI
  } rd_sel_t;

  typedef struct packed {
    logic    accept;
    rd_sel_t rd_sel;
    logic    step;
    logic    lo_cap;
    logic    wr;
    logic    hold_res;
    logic    out_load;
    logic    out_from_step;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic rejected;
    logic below;
    logic step_more;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/sbis_ctrl.sv =====
`default_nettype none
module sbis_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  input  wire sbis_pkg::dp_stat_t stat,
  output sbis_pkg::dp_cmd_t      cmd
);
  import sbis_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_ACCEPT;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (stat.is_query) begin
            state_nxt = ST_QFIRST;
          end else if (stat.rejected) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_LLO;
          end
        end
      end
      ST_QFIRST: begin
        cmd.rd_sel = RD_MID;
        state_nxt  = stat.below ? ST_FIN : ST_QSTEP;
      end
      ST_QSTEP: begin
        cmd.rd_sel = RD_NEXT;
        cmd.step   = 1'b1;
        if (!stat.step_more) begin
          if (out_free) begin
            cmd.out_load      = 1'b1;
            cmd.out_from_step = 1'b1;
            state_nxt         = ST_IDLE;
          end else begin
            cmd.hold_res = 1'b1;
            state_nxt    = ST_FIN;
          end
        end
      end
      ST_LLO: begin
        cmd.rd_sel = RD_HI;
        cmd.lo_cap = 1'b1;
        state_nxt  = ST_LHI;
      end
      ST_LHI: begin
        cmd.wr    = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sbis_datapath.sv =====
`default_nettype none
module sbis_datapath #(
  parameter int MAX_ENTRIES = sbis_pkg::DEF_MAX_ENTRIES,
  parameter int VALUE_BITS  = sbis_pkg::DEF_VALUE_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [sbis_pkg::CFG_BITS-1:0]       cfg_wdata,
  input  wire logic                                in_command,
  input  wire logic [sbis_pkg::IDX_BITS-1:0]       in_entry_index,
  input  wire logic signed [VALUE_BITS-1:0]        in_operand_value,
  input  wire sbis_pkg::dp_cmd_t                   cmd,
  output sbis_pkg::dp_stat_t                       stat,
  output logic [sbis_pkg::INTV_BITS-1:0]           out_interval_index,
  output logic                                     out_table_ascending,
  output logic                                     out_load_rejected
);
  import sbis_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CFG_BITS-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (int'(v) > MAX_ENTRIES) begin
      return CNT_W'(MAX_ENTRIES);
    end else begin
      return CNT_W'(v);
    end
  endfunction

  logic signed [VALUE_BITS-1:0] mem [MAX_ENTRIES];
  logic signed [VALUE_BITS-1:0] rdata_r;
  logic [IDX_W-1:0]             raddr;

  logic [CNT_W-1:0]             cnt_r;
  logic [MAX_ENTRIES-1:0]       marks_r;
  logic [MAX_ENTRIES-1:0]       mark_live;

  logic signed [VALUE_BITS-1:0] key_r;
  logic [IDX_W-1:0]             idx_r;
  logic                         rej_r;
  logic                         lo_mark_r;
  logic [CNT_W-1:0]             lower_r, upper_r, mid_r;
  logic [INTV_BITS-1:0]         res_r;

  logic [CNT_W:0]               sum0, sum_n;
  logic [CNT_W-1:0]             mid0, mid_n, l_n, u_n;
  logic                         gt;
  logic [INTV_BITS-1:0]         step_res;
  logic                         hi_ok;
  logic [IDX_W-1:0]             hi_idx;
  logic                         in_rej;

  assign in_rej = int'(in_entry_index) >= int'(cnt_r);
  assign hi_ok  = (int'(idx_r) + 1) < MAX_ENTRIES;
  assign hi_idx = IDX_W'(int'(idx_r) + 1);

  assign sum0  = {1'b0, lower_r} + {1'b0, upper_r};
  assign mid0  = sum0[CNT_W:1];
  assign gt    = key_r > rdata_r;
  assign l_n   = gt ? mid_r : lower_r;
  assign u_n   = gt ? upper_r : mid_r;
  assign sum_n = {1'b0, l_n} + {1'b0, u_n};
  assign mid_n = sum_n[CNT_W:1];
  assign step_res = (u_n == '0) ? INTV_BITS'(1) : INTV_BITS'(u_n);

  assign stat.is_query  = (in_command == CMD_QUERY);
  assign stat.rejected  = in_rej;
  assign stat.below     = key_r < rdata_r;
  assign stat.step_more = {1'b0, u_n} > ({1'b0, l_n} + (CNT_W + 1)'(1));

  always_comb begin
    raddr = '0;
    case (cmd.rd_sel)
      RD_ACCEPT: begin
        if (in_command == CMD_LOAD && in_entry_index != '0 && !in_rej) begin
          raddr = IDX_W'(in_entry_index - IDX_BITS'(1));
        end
      end
      RD_MID:  raddr = IDX_W'(mid0);
      RD_NEXT: raddr = IDX_W'(mid_n);
      RD_HI:   raddr = hi_ok ? hi_idx : '0;
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[idx_r] <= key_r;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= clamp_cnt(CFG_RESET);
      marks_r <= '0;
    end else begin
      if (cfg_we) begin
        cnt_r <= clamp_cnt(cfg_wdata);
      end
      if (cmd.wr) begin
        if (idx_r != '0) begin
          marks_r[idx_r] <= lo_mark_r;
        end
        if (hi_ok) begin
          marks_r[hi_idx] <= rdata_r < key_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r   <= in_operand_value;
      idx_r   <= IDX_W'(in_entry_index);
      rej_r   <= (in_command == CMD_LOAD) && in_rej;
      lower_r <= '0;
      upper_r <= cnt_r;
      res_r   <= '0;
    end
    if (cmd.rd_sel == RD_MID) begin
      mid_r <= mid0;
    end
    if (cmd.step) begin
      lower_r <= l_n;
      upper_r <= u_n;
      mid_r   <= mid_n;
    end
    if (cmd.hold_res) begin
      res_r <= step_res;
    end
    if (cmd.lo_cap) begin
      lo_mark_r <= (idx_r != '0) && (key_r < rdata_r);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      mark_live[i] = marks_r[i] && (i >= 1) && (i < int'(cnt_r));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_interval_index  <= cmd.out_from_step ? step_res : res_r;
      out_table_ascending <= ~|mark_live;
      out_load_rejected   <= rej_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sorted_breakpoint_interval_search_top.sv =====
// Query: ST_QFIRST, then at most max(1, ceil(log2(n))) bisection steps in ST_QSTEP (n = entries
//   in use) before the result is registered; when key < entry 0 it goes straight to ST_FIN.
// Load: read both neighbors (at accept and in ST_LLO), then write in ST_LHI; a rejected load skips to ST_FIN.
// One item in flight; the next beat is taken in the cycle after the result is registered, also
//   while it waits in the output register; a full output register holds the item back.
// Reset (rst_n low, sync): idle, output empty, order marks cleared, entries_in_use 16.
`default_nettype none
module sorted_breakpoint_interval_search_top #(
  parameter int MAX_ENTRIES = sbis_pkg::DEF_MAX_ENTRIES,
  parameter int VALUE_BITS  = sbis_pkg::DEF_VALUE_BITS,
  parameter int IN_W        = ((sbis_pkg::IDX_BITS + VALUE_BITS + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sbis_pkg::CFG_BITS-1:0] cfg_wdata,   // entries_in_use
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [IN_W-1:0]               in_tdata,    // entry_index, operand_value
  input  wire logic [0:0]                    in_tuser,    // command
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [sbis_pkg::OUT_BITS-1:0]      out_tdata    // interval_index, table_ascending,
                                                          // load_rejected
);
  import sbis_pkg::*;

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic [INTV_BITS-1:0] interval_index;
  logic                 table_ascending;
  logic                 load_rejected;

  sbis_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd)
  );

  sbis_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_command          (in_tuser[0]),
    .in_entry_index      (in_tdata[IDX_BITS-1:0]),
    .in_operand_value    (in_tdata[IDX_BITS+VALUE_BITS-1:IDX_BITS]),
    .cmd                 (cmd),
    .stat                (stat),
    .out_interval_index  (interval_index),
    .out_table_ascending (table_ascending),
    .out_load_rejected   (load_rejected)
  );

  assign out_tdata = {1'b0, load_rejected, table_ascending, interval_index};

endmodule
`default_nettype wire

// ===== rtl/core/sbis_checker.sv =====
`default_nettype none
module sbis_checker #(
  parameter int MAX_ENTRIES = sbis_pkg::DEF_MAX_ENTRIES
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [sbis_pkg::OUT_BITS-1:0] out_tdata
);
  import sbis_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous beat in work");

  a_reject_no_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |-> out_tdata[4:0] == '0)
    else $error("rejected load reports an interval");

  a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> int'(out_tdata[4:0]) <= MAX_ENTRIES)
    else $error("interval beyond table depth");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sorted_breakpoint_interval_search_top sbis_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_sbis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
